// ===== hw/rtl/epv_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder period velocity package
// Widths, register indexes, reset values and event codes for the meter.
// ----------------------------------------------------------------------------
package epv_pkg;

  localparam int unsigned CapW   = 16;
  localparam int unsigned SpeedW = 32;
  localparam int unsigned PprW   = 10;
  localparam int unsigned CountW = 8;
  localparam int unsigned DeltaW = CountW + CapW;
  localparam int unsigned DenW   = PprW + DeltaW;
  localparam int unsigned StepW  = $clog2(SpeedW);
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SpeedW-1:0] TicksReset   = 32'd60000000;
  localparam logic [PprW-1:0]   PprReset     = 10'd12;
  localparam logic [CountW-1:0] TimeoutReset = 8'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_MINUTE = 2'd0,
    CFG_PULSES_PER_REV   = 2'd1,
    CFG_TIMEOUT_LIMIT    = 2'd2
  } cfg_index_t;

  localparam logic REQ_CAPTURE  = 1'b0;
  localparam logic REQ_OVERFLOW = 1'b1;

endpackage

// ===== hw/rtl/encoder_period_velocity_top.sv =====
// Encoder period speed meter. Each input transaction is either a timer
// overflow or an edge capture with the 16-bit captured timer value; each one
// yields exactly one speed transaction in rpm. An overflow, or a capture with
// an elapsed time of zero or less, goes straight to the output load. Other
// captures form the elapsed ticks on acceptance, multiply by pulses per rev,
// run the radix-2 restoring divider (one quotient bit per cycle) and load the
// output register; zero pulses per rev skips the divider and loads all ones.
// The load waits, and the input stays blocked, for as long as the output
// register still holds an untaken result. The input is accepted again once
// the result is in the output register, even while it still waits to be taken.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
// Encoder period velocity top level
// Overflow counting, elapsed-period capture and a serial divider.
// ----------------------------------------------------------------------------
module encoder_period_velocity_top
  import epv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [SpeedW-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [CapW-1:0]     capture_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SpeedW-1:0]   speed_rpm
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t              state;
  logic [SpeedW-1:0]   ticks_per_minute;
  logic [PprW-1:0]     pulses_per_rev;
  logic [CountW-1:0]   timeout_limit;
  logic [CapW-1:0]     last_capture;
  logic [SpeedW-1:0]   held_speed;
  logic [CountW-1:0]   overflow_count;
  logic [DeltaW-1:0]   delta;
  logic [DenW-1:0]     den;
  logic [DenW:0]       rem;
  logic [SpeedW-1:0]   quo;
  logic [StepW-1:0]    step;
  logic [SpeedW-1:0]   res;

  logic                in_fire;
  logic [DeltaW+1:0]   delta_full;
  logic                delta_pos;
  logic [CountW-1:0]   count_inc;
  logic [DenW:0]       rem_sh;
  logic [DenW:0]       rem_diff;
  logic                rem_ge;
  logic [SpeedW-1:0]   quo_next;
  logic                out_free;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign delta_full = {2'b00, overflow_count, capture_value}
                    - {{(DeltaW+2-CapW){1'b0}}, last_capture};
  assign delta_pos  = !delta_full[DeltaW+1] && (|delta_full[DeltaW-1:0]);
  assign count_inc  = (overflow_count == {CountW{1'b1}}) ? overflow_count
                                                         : overflow_count + 1'b1;

  assign rem_sh   = {rem[DenW-1:0], quo[SpeedW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, den});
  assign rem_diff = rem_sh - {1'b0, den};
  assign quo_next = {quo[SpeedW-2:0], rem_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_minute <= TicksReset;
      pulses_per_rev   <= PprReset;
      timeout_limit    <= TimeoutReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_MINUTE: ticks_per_minute <= cfg_data;
        CFG_PULSES_PER_REV:   pulses_per_rev   <= cfg_data[PprW-1:0];
        CFG_TIMEOUT_LIMIT:    timeout_limit    <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      last_capture   <= '0;
      held_speed     <= '0;
      overflow_count <= '0;
      step           <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (req_type == REQ_OVERFLOW) begin
              overflow_count <= count_inc;
              if (count_inc >= timeout_limit) begin
                held_speed <= '0;
                res        <= '0;
              end else begin
                res <= held_speed;
              end
              state <= ST_DONE;
            end else begin
              last_capture <= capture_value;
              delta        <= delta_full[DeltaW-1:0];
              if (delta_pos) begin
                state <= ST_MUL;
              end else begin
                res   <= '0;
                state <= ST_DONE;
              end
            end
          end
        end
        ST_MUL: begin
          if (pulses_per_rev == '0) begin
            res            <= '1;
            held_speed     <= '1;
            overflow_count <= '0;
            state          <= ST_DONE;
          end else begin
            den   <= {{DeltaW{1'b0}}, pulses_per_rev} * {{PprW{1'b0}}, delta};
            rem   <= '0;
            quo   <= ticks_per_minute;
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_ge ? rem_diff : rem_sh;
          quo  <= quo_next;
          step <= step + 1'b1;
          if (step == {StepW{1'b1}}) begin
            res            <= quo_next;
            held_speed     <= quo_next;
            overflow_count <= '0;
            state          <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            speed_rpm <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < {1'b0, den}))
    else $error("divider remainder not below divisor");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req_type == REQ_OVERFLOW && overflow_count == {CountW{1'b1}})
      |=> (overflow_count == {CountW{1'b1}}))
    else $error("overflow count wrapped");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req_type == REQ_OVERFLOW && count_inc >= timeout_limit)
      |=> (held_speed == '0 && res == '0))
    else $error("timeout did not clear held speed");

endmodule
